### rtl/pareto_front_insert_assert.svh
// Assertion macros used by the top level of the Pareto front block.
// Each macro expects clk and rst_n in scope.
`ifndef PARETO_FRONT_INSERT_ASSERT_SVH
`define PARETO_FRONT_INSERT_ASSERT_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge
`define PFI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold at a clock edge out of reset
`define PFI_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

### rtl/pfi_pkg.sv
// ----------------------------------------------------------------------------
// pfi_pkg
// Types, sizes and helpers shared by the Pareto front insert block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfi_pkg;

  // Number of stored pairs
  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Result field widths
  localparam int MASK_W     = 16;
  localparam int SIZE_W     = 5;
  localparam int SIZE_MAX   = (1 << SIZE_W) - 1;

  // Queue between front and back (depth is a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] info_bound;
    logic        [31:0] path_cost;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [MASK_W-1:0] removed_mask;
    logic [SIZE_W-1:0] list_size;
    logic              overflow;
  } out_item_t;

  // One stored pair
  typedef struct packed {
    logic signed [31:0] info;
    logic        [31:0] cost;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DONE
  } back_state_t;

  // Reported list size saturates at the field maximum
  function automatic logic [SIZE_W-1:0] sat_size(input logic [CNT_W-1:0] cnt);
    if (int'(cnt) > SIZE_MAX) begin
      return SIZE_W'(SIZE_MAX);
    end
    return SIZE_W'(cnt);
  endfunction

endpackage

### rtl/pareto_front_insert.sv
// ----------------------------------------------------------------------------
// pareto_front_insert
// Pareto front of (information bound, cost) pairs with dominance filtering.
//
//   Channel   Ports                     Transfer
//   input     start, busy, in_item      taken when start=1 and busy=0
//   result    out_valid, out_item       one-cycle strobe, always taken
//
// An insert is paced by the walk over the pair store, which has one read port
// and reads one pair per cycle. A clear needs no walk in the engine.
// A two-item queue sits between the input and the engine; busy is high only
// while that queue is full. Synchronous active-low reset empties the list
// and the queue; the pair store itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pareto_front_insert_assert.svh"

module pareto_front_insert (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pfi_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output pfi_pkg::out_item_t out_item
);

  logic              q_valid;
  logic              q_pop;
  pfi_pkg::in_item_t q_item;

  // Input handshake and item queue
  pfi_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // List engine
  pfi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Checks
  `PFI_ASSERT_IMPL(a_pop_needs_item, q_pop, q_valid, "engine popped an empty queue")
  `PFI_ASSERT_NEVER(a_acc_and_ovf, out_valid && out_item.accepted && out_item.overflow,
    "item both accepted and dropped")
  `PFI_ASSERT_IMPL(a_ovf_no_removal, out_valid && out_item.overflow,
    out_item.removed_mask == '0, "overflow reported with removed entries")
  `PFI_ASSERT_IMPL(a_size_bound, out_valid,
    int'(out_item.list_size) <= pfi_pkg::LIST_DEPTH, "list size beyond depth")

endmodule

### rtl/pfi_front.sv
// ----------------------------------------------------------------------------
// pfi_front
// Input side: takes items on the start handshake and queues them for the
// list engine, so the two sides stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfi_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pfi_pkg::in_item_t in_item,
  output logic              busy,
  output logic              q_valid,
  output pfi_pkg::in_item_t q_item,
  input  logic              q_pop
);

  logic [pfi_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pfi_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pfi_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  pfi_pkg::in_item_t          slot_r [pfi_pkg::QUEUE_DEPTH];
  logic                       push;

  // Handshake and queue status
  assign busy    = (cnt_r == pfi_pkg::QCNT_W'(pfi_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = push  ? pfi_pkg::QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? pfi_pkg::QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = pfi_pkg::QCNT_W'(cnt_r + pfi_pkg::QCNT_W'(push)
                                        - pfi_pkg::QCNT_W'(q_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

### rtl/pfi_back.sv
// ----------------------------------------------------------------------------
// pfi_back
// List engine: walks the stored pairs one per cycle, drops dominated ones,
// compacts survivors in place, appends the candidate unless dominated or full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfi_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  pfi_pkg::in_item_t  q_item,
  output logic               q_pop,
  output logic               out_valid,
  output pfi_pkg::out_item_t out_item
);

  pfi_pkg::back_state_t state_r, state_nxt;

  logic [pfi_pkg::CNT_W-1:0] count_r, count_nxt;   // stored pairs
  logic [pfi_pkg::CNT_W-1:0] issue_r, issue_nxt;   // next entry to read
  logic [pfi_pkg::CNT_W-1:0] wr_r, wr_nxt;         // compaction write slot
  logic [pfi_pkg::IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic                      pend_r, pend_nxt;     // read data waiting
  logic                      rej_r, rej_nxt;
  logic                      out_valid_r, out_valid_nxt;

  pfi_pkg::in_item_t         cand_r, cand_nxt;
  logic [pfi_pkg::MASK_W-1:0] mask_r, mask_nxt;
  pfi_pkg::out_item_t        out_item_r, out_item_nxt;

  // Pair store
  pfi_pkg::entry_t           mem [pfi_pkg::LIST_DEPTH];
  pfi_pkg::entry_t           rd_data_r;
  logic                      rd_en;
  logic [pfi_pkg::IDX_W-1:0] rd_addr;
  logic                      mem_we;
  logic [pfi_pkg::IDX_W-1:0] mem_waddr;
  pfi_pkg::entry_t           mem_wdata;

  logic                      ent_gone, ent_dom;

  // Dominance tests of the entry just read against the candidate
  always_comb begin
    ent_gone = ($signed(rd_data_r.info) >= $signed(cand_r.info_bound))
            && (rd_data_r.cost >= cand_r.path_cost);
    ent_dom  = ($signed(rd_data_r.info) <= $signed(cand_r.info_bound))
            && (rd_data_r.cost <= cand_r.path_cost);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    wr_nxt        = wr_r;
    cmp_idx_nxt   = cmp_idx_r;
    pend_nxt      = 1'b0;
    rej_nxt       = rej_r;
    out_valid_nxt = 1'b0;
    cand_nxt      = cand_r;
    mask_nxt      = mask_r;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = issue_r[pfi_pkg::IDX_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = wr_r[pfi_pkg::IDX_W-1:0];
    mem_wdata     = rd_data_r;

    unique case (state_r)
      pfi_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cand_nxt = q_item;
          if (q_item.cmd == pfi_pkg::CMD_CLEAR) begin
            count_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{accepted: 1'b0, removed_mask: '0,
                              list_size: '0, overflow: 1'b0};
          end else begin
            issue_nxt = '0;
            wr_nxt    = '0;
            mask_nxt  = '0;
            rej_nxt   = 1'b0;
            state_nxt = pfi_pkg::BK_WALK;
          end
        end
      end

      pfi_pkg::BK_WALK: begin
        // Judge the entry read last cycle
        if (pend_r && !rej_r) begin
          if (ent_gone) begin
            mask_nxt = mask_r | (pfi_pkg::MASK_W'(1) << cmp_idx_r);
          end else if (ent_dom) begin
            rej_nxt = 1'b1;
          end else begin
            // Survivor moves down to the next free slot
            mem_we = 1'b1;
            wr_nxt = pfi_pkg::CNT_W'(wr_r + 1'b1);
          end
        end
        // Read the next entry while any remain and the candidate is not rejected
        if (!rej_r && (issue_r < count_r)) begin
          rd_en       = 1'b1;
          pend_nxt    = 1'b1;
          cmp_idx_nxt = issue_r[pfi_pkg::IDX_W-1:0];
          issue_nxt   = pfi_pkg::CNT_W'(issue_r + 1'b1);
        end else begin
          state_nxt = pfi_pkg::BK_DONE;
        end
      end

      pfi_pkg::BK_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = pfi_pkg::BK_IDLE;
        if (rej_r) begin
          out_item_nxt = '{accepted: 1'b0, removed_mask: '0,
                           list_size: pfi_pkg::sat_size(count_r), overflow: 1'b0};
        end else if (int'(wr_r) >= pfi_pkg::LIST_DEPTH) begin
          // Full with nothing removed: candidate dropped
          count_nxt    = wr_r;
          out_item_nxt = '{accepted: 1'b0, removed_mask: mask_r,
                           list_size: pfi_pkg::sat_size(wr_r), overflow: 1'b1};
        end else begin
          mem_we       = 1'b1;
          mem_wdata    = '{info: cand_r.info_bound, cost: cand_r.path_cost};
          count_nxt    = pfi_pkg::CNT_W'(wr_r + 1'b1);
          out_item_nxt = '{accepted: 1'b1, removed_mask: mask_r,
                           list_size: pfi_pkg::sat_size(
                             pfi_pkg::CNT_W'(wr_r + 1'b1)),
                           overflow: 1'b0};
        end
      end

      default: begin
        state_nxt = pfi_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfi_pkg::BK_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
      issue_r     <= '0;
      wr_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
      issue_r     <= issue_nxt;
      wr_r        <= wr_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    mask_r     <= mask_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  // Pair store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### sim/pareto_front_insert_tb.sv
// ----------------------------------------------------------------------------
// pareto_front_insert_tb
// Self-checking bench for the Pareto front insert block.
//
// Clears and inserts are sent through the start/busy handshake. Each accepted
// item is run through a behavioural copy of the front (ordered pair list with
// dominance filtering and compaction). The expected result is queued, and
// every out_valid strobe is checked field by field against the oldest entry.
// Most stimulus builds fronts of mutually non-dominated pairs in shuffled
// order, then probes them with equal, dominating and dominated pairs, so the
// list fills, drains and overflows. Short bursts of narrow-range and fully
// random items are mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pareto_front_insert_tb;
  import pfi_pkg::*;

  localparam int ITEM_TARGET  = 1150;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 64;
  localparam int REPORT_MAX   = 10;

  // Behavioural front plus the queue of results still to come
  class front_checker;
    logic signed [31:0] info_st[LIST_DEPTH];
    logic        [31:0] cost_st[LIST_DEPTH];
    int                 count;
    out_item_t          pending_q[$];
    int errors, checked;
    int n_accept, n_reject, n_overflow, n_clear, n_removal;

    function new();
      count = 0;
      errors = 0;
      checked = 0;
      n_accept = 0;
      n_reject = 0;
      n_overflow = 0;
      n_clear = 0;
      n_removal = 0;
    endfunction

    // Work out the result of an accepted item and update the front
    function void note_item(input in_item_t it);
      out_item_t          res;
      logic signed [31:0] c_info;
      logic        [31:0] c_cost;
      bit                 kill[LIST_DEPTH];
      bit                 reject;
      int                 w;
      res    = '0;
      c_info = it.info_bound;
      c_cost = it.path_cost;
      reject = 1'b0;
      if (it.cmd == CMD_CLEAR) begin
        count = 0;
        n_clear++;
      end else begin
        for (int i = 0; i < LIST_DEPTH; i++) kill[i] = 1'b0;
        // walk stops at the first stored pair that dominates the candidate
        for (int i = 0; i < count && !reject; i++) begin
          if (info_st[i] >= c_info && cost_st[i] >= c_cost) begin
            kill[i] = 1'b1;
          end else if (info_st[i] <= c_info && cost_st[i] <= c_cost) begin
            reject = 1'b1;
          end
        end
        if (reject) begin
          n_reject++;
        end else begin
          // compact survivors in order
          w = 0;
          for (int i = 0; i < count; i++) begin
            if (kill[i]) begin
              if (i < MASK_W) res.removed_mask[i] = 1'b1;
            end else begin
              info_st[w] = info_st[i];
              cost_st[w] = cost_st[i];
              w++;
            end
          end
          count = w;
          if (count >= LIST_DEPTH) begin
            res.overflow = 1'b1;
            n_overflow++;
          end else begin
            info_st[count] = c_info;
            cost_st[count] = c_cost;
            count++;
            res.accepted = 1'b1;
            n_accept++;
          end
          if (res.removed_mask != '0) n_removal++;
        end
        res.list_size = (count > SIZE_MAX) ? SIZE_W'(SIZE_MAX) : SIZE_W'(count);
      end
      pending_q = {pending_q, res};
    endfunction

    // Compare a result strobe with the oldest expectation
    function void check_result(input out_item_t got);
      out_item_t exp_res;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("result with nothing expected: acc=%0d mask=%h size=%0d ovf=%0d",
                   got.accepted, got.removed_mask, got.list_size, got.overflow);
        return;
      end
      exp_res = pending_q.pop_front();
      checked++;
      if (got.accepted !== exp_res.accepted || got.removed_mask !== exp_res.removed_mask ||
          got.list_size !== exp_res.list_size || got.overflow !== exp_res.overflow) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("result %0d mismatch: exp acc=%0d mask=%h size=%0d ovf=%0d",
                   checked, exp_res.accepted, exp_res.removed_mask, exp_res.list_size,
                   exp_res.overflow);
          $display("  got acc=%0d mask=%h size=%0d ovf=%0d",
                   got.accepted, got.removed_mask, got.list_size, got.overflow);
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  front_checker tracker = new();
  int           items_sent = 0;
  int           cycle_count = 0;

  pareto_front_insert u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Observe both channels on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) tracker.note_item(in_item);
      if (out_valid) tracker.check_result(out_item);
    end
  end

  function automatic in_item_t mk_item(input logic cmd, input logic [31:0] info,
                                       input logic [31:0] cost);
    in_item_t it;
    it.cmd        = cmd;
    it.info_bound = info;
    it.path_cost  = cost;
    return it;
  endfunction

  // Present one item, hold it until taken, then maybe leave a gap
  task automatic issue_item(input in_item_t it);
    int idle_pct;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    idle_pct = (items_sent < ITEM_TARGET / 3)     ? 23 :
               (items_sent < 2 * ITEM_TARGET / 3) ? 81 : 0;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Clear, build a front of mutually non-dominated pairs in random order,
  // then probe it around its own points
  task automatic run_front();
    logic signed [31:0] infos[$];
    logic        [31:0] costs[$];
    in_item_t           pts[$];
    in_item_t           t;
    int                 n, j, probes;
    bit                 narrow;
    n = ($urandom_range(99) < 30) ? $urandom_range(16, 17) : $urandom_range(1, 15);
    narrow = ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) begin
      if (narrow) begin
        infos = {infos, 32'($urandom_range(40)) - 32'd20};
        costs = {costs, 32'($urandom_range(40))};
      end else begin
        infos = {infos, 32'($urandom)};
        costs = {costs, 32'($urandom)};
      end
    end
    infos.sort();
    costs.rsort();
    for (int i = 0; i < n; i++) pts = {pts, mk_item(CMD_INSERT, infos[i], costs[i])};
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = pts[i];
      pts[i] = pts[j];
      pts[j] = t;
    end
    issue_item(mk_item(CMD_CLEAR, $urandom, $urandom));
    foreach (pts[i]) issue_item(pts[i]);
    probes = $urandom_range(0, 4);
    for (int k = 0; k < probes; k++) begin
      t = pts[$urandom_range(n - 1)];
      case ($urandom_range(3))
        0: ;  // equal pair replaces the stored one
        1: begin  // slightly better in both: removes the stored pair
          if (t.info_bound != 32'sh8000_0000) t.info_bound = t.info_bound - 1;
          if (t.path_cost != 32'h0) t.path_cost = t.path_cost - 1;
        end
        2: begin  // slightly worse in both: rejected
          if (t.info_bound != 32'sh7FFF_FFFF) t.info_bound = t.info_bound + 1;
          if (t.path_cost != 32'hFFFF_FFFF) t.path_cost = t.path_cost + 1;
        end
        default: t = mk_item(CMD_INSERT, $urandom, $urandom);
      endcase
      issue_item(t);
    end
  endtask

  // Inserts on a small grid so ties and partial removals are common
  task automatic run_grid_burst();
    int n;
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++)
      issue_item(mk_item(CMD_INSERT, 32'($urandom_range(15)) - 32'd8,
                         32'($urandom_range(15))));
  endtask

  // Unstructured items, clears now and then
  task automatic run_noise();
    int   n;
    logic cmd;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(7) == 0) ? CMD_CLEAR : CMD_INSERT;
      issue_item(mk_item(cmd, $urandom, $urandom));
    end
  endtask

  initial begin
    int sel;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, extremes, mutual removal, equal pair, rejection
    issue_item(mk_item(CMD_CLEAR, 32'h0, 32'h0));
    issue_item(mk_item(CMD_INSERT, 32'h7FFF_FFFF, 32'h0000_0000));
    issue_item(mk_item(CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF));
    issue_item(mk_item(CMD_INSERT, 32'h8000_0000, 32'h0000_0000));
    issue_item(mk_item(CMD_INSERT, 32'h8000_0000, 32'h0000_0000));
    issue_item(mk_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_FFFF));
    issue_item(mk_item(CMD_CLEAR, 32'hAAAA_AAAA, 32'h5555_5555));
    // Directed: fill to sixteen, then a non-dominated pair that cannot fit
    for (int i = 0; i < LIST_DEPTH; i++)
      issue_item(mk_item(CMD_INSERT, 32'h8000_0000 + 32'(i) * 32'h1000_0000,
                         32'hFFFF_FFFF - 32'(i) * 32'h1000_0000));
    issue_item(mk_item(CMD_INSERT, 32'h7FFF_FFFF, 32'h0000_0000));

    // Random part
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(99);
      if (sel < 70) run_front();
      else if (sel < 85) run_grid_burst();
      else run_noise();
    end
    start <= 1'b0;

    while (tracker.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items: %0d merged, %0d dominated, %0d dropped when full, %0d clears",
             items_sent, tracker.n_accept, tracker.n_reject, tracker.n_overflow,
             tracker.n_clear);
    $display("%0d merges removed stored pairs; %0d results checked, %0d errors",
             tracker.n_removal, tracker.checked, tracker.errors + tracker.pending_q.size());
    if (tracker.errors == 0 && tracker.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### pareto_front_insert.f
+incdir+rtl
rtl/pfi_pkg.sv
rtl/pfi_front.sv
rtl/pfi_back.sv
rtl/pareto_front_insert.sv
sim/pareto_front_insert_tb.sv
